// ----- hw/rtl/lsau_pkg.sv -----
`default_nettype none

package lsau_pkg;

    // Operation codes
    localparam logic [4:0] OP_LUI  = 5'd0;
    localparam logic [4:0] OP_MFLO = 5'd1;
    localparam logic [4:0] OP_MFHI = 5'd2;
    localparam logic [4:0] OP_MTLO = 5'd3;
    localparam logic [4:0] OP_MTHI = 5'd4;
    localparam logic [4:0] OP_LB   = 5'd5;
    localparam logic [4:0] OP_LBU  = 5'd6;
    localparam logic [4:0] OP_LH   = 5'd7;
    localparam logic [4:0] OP_LHU  = 5'd8;
    localparam logic [4:0] OP_LW   = 5'd9;
    localparam logic [4:0] OP_LWL  = 5'd10;
    localparam logic [4:0] OP_LWR  = 5'd11;
    localparam logic [4:0] OP_SB   = 5'd12;
    localparam logic [4:0] OP_SH   = 5'd13;
    localparam logic [4:0] OP_SW   = 5'd14;
    localparam logic [4:0] OP_SWL  = 5'd15;
    localparam logic [4:0] OP_SWR  = 5'd16;

    // Bus write sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Byte lanes within a word
    localparam logic [1:0] LANE_0 = 2'd0;
    localparam logic [1:0] LANE_1 = 2'd1;
    localparam logic [1:0] LANE_2 = 2'd2;

    // Merge masks for partial-word loads and stores
    localparam logic [31:0] MASK_LO24 = 32'h00FF_FFFF;
    localparam logic [31:0] MASK_LO16 = 32'h0000_FFFF;
    localparam logic [31:0] MASK_LO8  = 32'h0000_00FF;
    localparam logic [31:0] MASK_HI8  = 32'hFF00_0000;
    localparam logic [31:0] MASK_HI16 = 32'hFFFF_0000;
    localparam logic [31:0] MASK_HI24 = 32'hFFFF_FF00;

    // One operation in
    typedef struct packed {
        logic [4:0]         operation;
        logic [31:0]        base_value;
        logic signed [15:0] offset;
        logic [31:0]        rt_value;
        logic [31:0]        memory_word;
    } t_ls_in;

    // One result out
    typedef struct packed {
        logic [31:0] bus_address;
        logic        write_enable;
        logic [1:0]  write_size;
        logic [31:0] write_data;
        logic        reg_write;
        logic [31:0] reg_value;
    } t_ls_out;

    // Update of the kept hi/lo registers
    typedef struct packed {
        logic        wr_hi;
        logic        wr_lo;
        logic [31:0] value;
    } t_hilo_upd;

endpackage

`default_nettype wire

// ----- hw/rtl/lsau_exec.sv -----
`default_nettype none

module lsau_exec (
    input  wire lsau_pkg::t_ls_in     i_op,
    input  wire logic                 i_cache_isolated,
    input  wire logic [31:0]          i_hi,
    input  wire logic [31:0]          i_lo,
    output lsau_pkg::t_ls_out         o_res,
    output lsau_pkg::t_hilo_upd       o_hilo
);

    logic [31:0] ea;
    logic [31:0] aligned;
    logic [1:0]  lane;
    logic [31:0] mem;
    logic [31:0] rt;
    logic [7:0]  ld_byte;
    logic [15:0] ld_half;
    logic        mem_op;
    lsau_pkg::t_ls_out res;

    // Effective address
    assign ea      = i_op.base_value + {{16{i_op.offset[15]}}, i_op.offset};
    assign aligned = {ea[31:2], 2'b00};
    assign lane    = ea[1:0];
    assign mem     = i_op.memory_word;
    assign rt      = i_op.rt_value;
    assign mem_op  = (i_op.operation >= lsau_pkg::OP_LB) &&
                     (i_op.operation <= lsau_pkg::OP_SWR);

    // Byte and halfword lane select
    always_comb begin
        case (lane)
            lsau_pkg::LANE_0: ld_byte = mem[7:0];
            lsau_pkg::LANE_1: ld_byte = mem[15:8];
            lsau_pkg::LANE_2: ld_byte = mem[23:16];
            default:          ld_byte = mem[31:24];
        endcase
    end
    assign ld_half = ea[1] ? mem[31:16] : mem[15:0];

    // Operation decode and data alignment
    always_comb begin
        res    = '0;
        o_hilo = '0;
        o_hilo.value = i_op.base_value;
        case (i_op.operation)
            lsau_pkg::OP_LUI: begin
                res.reg_write = 1'b1;
                res.reg_value = {i_op.offset, 16'h0000};
            end
            lsau_pkg::OP_MFLO: begin
                res.reg_write = 1'b1;
                res.reg_value = i_lo;
            end
            lsau_pkg::OP_MFHI: begin
                res.reg_write = 1'b1;
                res.reg_value = i_hi;
            end
            lsau_pkg::OP_MTLO: o_hilo.wr_lo = 1'b1;
            lsau_pkg::OP_MTHI: o_hilo.wr_hi = 1'b1;
            lsau_pkg::OP_LB: begin
                res.bus_address = ea;
                res.reg_write   = 1'b1;
                res.reg_value   = {{24{ld_byte[7]}}, ld_byte};
            end
            lsau_pkg::OP_LBU: begin
                res.bus_address = ea;
                res.reg_write   = 1'b1;
                res.reg_value   = {24'h000000, ld_byte};
            end
            lsau_pkg::OP_LH: begin
                res.bus_address = ea;
                res.reg_write   = 1'b1;
                res.reg_value   = {{16{ld_half[15]}}, ld_half};
            end
            lsau_pkg::OP_LHU: begin
                res.bus_address = ea;
                res.reg_write   = 1'b1;
                res.reg_value   = {16'h0000, ld_half};
            end
            lsau_pkg::OP_LW: begin
                res.bus_address = aligned;
                res.reg_write   = 1'b1;
                res.reg_value   = mem;
            end
            lsau_pkg::OP_LWL: begin
                res.bus_address = aligned;
                res.reg_write   = 1'b1;
                case (lane)
                    lsau_pkg::LANE_0: res.reg_value = (rt & lsau_pkg::MASK_LO24) | (mem << 24);
                    lsau_pkg::LANE_1: res.reg_value = (rt & lsau_pkg::MASK_LO16) | (mem << 16);
                    lsau_pkg::LANE_2: res.reg_value = (rt & lsau_pkg::MASK_LO8) | (mem << 8);
                    default:          res.reg_value = mem;
                endcase
            end
            lsau_pkg::OP_LWR: begin
                res.bus_address = aligned;
                res.reg_write   = 1'b1;
                case (lane)
                    lsau_pkg::LANE_0: res.reg_value = mem;
                    lsau_pkg::LANE_1: res.reg_value = (rt & lsau_pkg::MASK_HI8) | (mem >> 8);
                    lsau_pkg::LANE_2: res.reg_value = (rt & lsau_pkg::MASK_HI16) | (mem >> 16);
                    default:          res.reg_value = (rt & lsau_pkg::MASK_HI24) | (mem >> 24);
                endcase
            end
            lsau_pkg::OP_SB: begin
                res.bus_address  = ea;
                res.write_enable = 1'b1;
                res.write_size   = lsau_pkg::SIZE_BYTE;
                res.write_data   = rt & lsau_pkg::MASK_LO8;
            end
            lsau_pkg::OP_SH: begin
                res.bus_address  = ea;
                res.write_enable = 1'b1;
                res.write_size   = lsau_pkg::SIZE_HALF;
                res.write_data   = rt & lsau_pkg::MASK_LO16;
            end
            lsau_pkg::OP_SW: begin
                res.bus_address  = ea;
                res.write_enable = 1'b1;
                res.write_size   = lsau_pkg::SIZE_WORD;
                res.write_data   = rt;
            end
            lsau_pkg::OP_SWL: begin
                res.bus_address  = aligned;
                res.write_enable = 1'b1;
                res.write_size   = lsau_pkg::SIZE_WORD;
                case (lane)
                    lsau_pkg::LANE_0: res.write_data = (mem & lsau_pkg::MASK_HI24) | (rt >> 24);
                    lsau_pkg::LANE_1: res.write_data = (mem & lsau_pkg::MASK_HI16) | (rt >> 16);
                    lsau_pkg::LANE_2: res.write_data = (mem & lsau_pkg::MASK_HI8) | (rt >> 8);
                    default:          res.write_data = rt;
                endcase
            end
            lsau_pkg::OP_SWR: begin
                res.bus_address  = aligned;
                res.write_enable = 1'b1;
                res.write_size   = lsau_pkg::SIZE_WORD;
                case (lane)
                    lsau_pkg::LANE_0: res.write_data = rt;
                    lsau_pkg::LANE_1: res.write_data = (mem & lsau_pkg::MASK_LO8) | (rt << 8);
                    lsau_pkg::LANE_2: res.write_data = (mem & lsau_pkg::MASK_LO16) | (rt << 16);
                    default:          res.write_data = (mem & lsau_pkg::MASK_LO24) | (rt << 24);
                endcase
            end
            default: begin
                res = '0;
            end
        endcase

        // Cache isolation: address still shown, no bus or register effect
        if (mem_op && i_cache_isolated) begin
            res.write_enable = 1'b0;
            res.write_size   = lsau_pkg::SIZE_BYTE;
            res.write_data   = '0;
            res.reg_write    = 1'b0;
            res.reg_value    = '0;
        end
    end

    assign o_res = res;

endmodule

`default_nettype wire

// ----- hw/rtl/mips_load_store_align_unit.sv -----
// An accepted input is held in the input register, then passes through the alignment
// datapath into the output register, where a stalled output holds it.
// Throughput: one operation per cycle unless the output stalls; the input register feeds
// one pass of address add and lane alignment into the result register.
// Reset (i_rst_n low, synchronous): pipeline empty, hi/lo cleared, cache
// isolation off. A held result stalls the input only when both stages are full.
`default_nettype none

module mips_load_store_align_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire lsau_pkg::t_ls_in   i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output lsau_pkg::t_ls_out       o_out_data
);

    logic                 r_cache_isolated;
    logic [31:0]          r_hi;
    logic [31:0]          r_lo;
    logic                 r_in_valid;
    lsau_pkg::t_ls_in     r_in;
    logic                 r_out_valid;
    lsau_pkg::t_ls_out    r_out;
    lsau_pkg::t_ls_out    n_out;
    lsau_pkg::t_hilo_upd  hilo_upd;
    logic                 advance;
    logic                 in_xfer;

    // Stage handshake
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Alignment datapath
    lsau_exec u_exec (
        .i_op             (r_in),
        .i_cache_isolated (r_cache_isolated),
        .i_hi             (r_hi),
        .i_lo             (r_lo),
        .o_res            (n_out),
        .o_hilo           (hilo_upd)
    );

    // Control state, hi/lo and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_isolated <= 1'b0;
            r_hi             <= '0;
            r_lo             <= '0;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cache_isolated <= i_cfg_data;
            end
            if (r_in_valid && advance) begin
                if (hilo_upd.wr_hi) begin
                    r_hi <= hilo_upd.value;
                end
                if (hilo_upd.wr_lo) begin
                    r_lo <= hilo_upd.value;
                end
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
        if (r_in_valid && advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- tb/sv/mips_load_store_align_unit_tb.sv -----
`default_nettype none

module mips_load_store_align_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 132;
    localparam int NUM_PHASES   = 8;
    localparam int SETTLE_CYCLES = 10;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_data = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    lsau_pkg::t_ls_in  i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    lsau_pkg::t_ls_out o_out_data;

    // Operations waiting to be driven, and results owed by the block
    lsau_pkg::t_ls_in  pending_ops[$];
    lsau_pkg::t_ls_out expected_results[$];

    // Shadow copy of the block's state and its one register
    logic [31:0] hi_copy = '0;
    logic [31:0] lo_copy = '0;
    logic        isolate_copy = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int ops_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;

    mips_load_store_align_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Expected result of one operation; updates hi/lo as the block does
    function automatic lsau_pkg::t_ls_out align_predict(lsau_pkg::t_ls_in op_in);
        lsau_pkg::t_ls_out r;
        logic [31:0] ea;
        logic [31:0] mem;
        logic [31:0] rt;
        logic [31:0] picked;
        logic [1:0]  lane;
        logic        is_mem;
        r = '0;
        mem = op_in.memory_word;
        rt = op_in.rt_value;
        ea = op_in.base_value + {{16{op_in.offset[15]}}, op_in.offset};
        lane = ea[1:0];
        is_mem = (op_in.operation >= lsau_pkg::OP_LB) &&
                 (op_in.operation <= lsau_pkg::OP_SWR);
        if (is_mem) begin
            if (op_in.operation == lsau_pkg::OP_LW || op_in.operation == lsau_pkg::OP_LWL ||
                op_in.operation == lsau_pkg::OP_LWR ||
                op_in.operation == lsau_pkg::OP_SWL ||
                op_in.operation == lsau_pkg::OP_SWR) begin
                r.bus_address = {ea[31:2], 2'b00};
            end else begin
                r.bus_address = ea;
            end
        end
        case (op_in.operation)
            lsau_pkg::OP_LUI: begin
                r.reg_write = 1'b1;
                r.reg_value = {op_in.offset, 16'h0000};
            end
            lsau_pkg::OP_MFLO: begin
                r.reg_write = 1'b1;
                r.reg_value = lo_copy;
            end
            lsau_pkg::OP_MFHI: begin
                r.reg_write = 1'b1;
                r.reg_value = hi_copy;
            end
            lsau_pkg::OP_MTLO: lo_copy = op_in.base_value;
            lsau_pkg::OP_MTHI: hi_copy = op_in.base_value;
            lsau_pkg::OP_LB, lsau_pkg::OP_LBU: begin
                picked = mem >> (8 * lane);
                r.reg_write = 1'b1;
                if (op_in.operation == lsau_pkg::OP_LB)
                    r.reg_value = {{24{picked[7]}}, picked[7:0]};
                else
                    r.reg_value = picked & lsau_pkg::MASK_LO8;
            end
            lsau_pkg::OP_LH, lsau_pkg::OP_LHU: begin
                // address bit 0 plays no part
                picked = ea[1] ? (mem >> 16) : mem;
                r.reg_write = 1'b1;
                if (op_in.operation == lsau_pkg::OP_LH)
                    r.reg_value = {{16{picked[15]}}, picked[15:0]};
                else
                    r.reg_value = picked & lsau_pkg::MASK_LO16;
            end
            lsau_pkg::OP_LW: begin
                r.reg_write = 1'b1;
                r.reg_value = mem;
            end
            lsau_pkg::OP_LWL: begin
                r.reg_write = 1'b1;
                case (lane)
                    lsau_pkg::LANE_0: r.reg_value = (rt & lsau_pkg::MASK_LO24) | (mem << 24);
                    lsau_pkg::LANE_1: r.reg_value = (rt & lsau_pkg::MASK_LO16) | (mem << 16);
                    lsau_pkg::LANE_2: r.reg_value = (rt & lsau_pkg::MASK_LO8) | (mem << 8);
                    default: r.reg_value = mem;
                endcase
            end
            lsau_pkg::OP_LWR: begin
                r.reg_write = 1'b1;
                case (lane)
                    lsau_pkg::LANE_0: r.reg_value = mem;
                    lsau_pkg::LANE_1: r.reg_value = (rt & lsau_pkg::MASK_HI8) | (mem >> 8);
                    lsau_pkg::LANE_2: r.reg_value = (rt & lsau_pkg::MASK_HI16) | (mem >> 16);
                    default: r.reg_value = (rt & lsau_pkg::MASK_HI24) | (mem >> 24);
                endcase
            end
            lsau_pkg::OP_SB: begin
                r.write_enable = 1'b1;
                r.write_size = lsau_pkg::SIZE_BYTE;
                r.write_data = rt & lsau_pkg::MASK_LO8;
            end
            lsau_pkg::OP_SH: begin
                r.write_enable = 1'b1;
                r.write_size = lsau_pkg::SIZE_HALF;
                r.write_data = rt & lsau_pkg::MASK_LO16;
            end
            lsau_pkg::OP_SW: begin
                r.write_enable = 1'b1;
                r.write_size = lsau_pkg::SIZE_WORD;
                r.write_data = rt;
            end
            lsau_pkg::OP_SWL: begin
                r.write_enable = 1'b1;
                r.write_size = lsau_pkg::SIZE_WORD;
                case (lane)
                    lsau_pkg::LANE_0: r.write_data = (mem & lsau_pkg::MASK_HI24) | (rt >> 24);
                    lsau_pkg::LANE_1: r.write_data = (mem & lsau_pkg::MASK_HI16) | (rt >> 16);
                    lsau_pkg::LANE_2: r.write_data = (mem & lsau_pkg::MASK_HI8) | (rt >> 8);
                    default: r.write_data = rt;
                endcase
            end
            lsau_pkg::OP_SWR: begin
                r.write_enable = 1'b1;
                r.write_size = lsau_pkg::SIZE_WORD;
                case (lane)
                    lsau_pkg::LANE_0: r.write_data = rt;
                    lsau_pkg::LANE_1: r.write_data = (mem & lsau_pkg::MASK_LO8) | (rt << 8);
                    lsau_pkg::LANE_2: r.write_data = (mem & lsau_pkg::MASK_LO16) | (rt << 16);
                    default: r.write_data = (mem & lsau_pkg::MASK_LO24) | (rt << 24);
                endcase
            end
            default: ;
        endcase
        // isolation kills the bus write and the writeback, not the address
        if (is_mem && isolate_copy) begin
            r.write_enable = 1'b0;
            r.write_size = lsau_pkg::SIZE_BYTE;
            r.write_data = '0;
            r.reg_write = 1'b0;
            r.reg_value = '0;
        end
        return r;
    endfunction

    function automatic void push_op(logic [4:0] op, logic [31:0] base, logic [15:0] offs,
                                    logic [31:0] rt, logic [31:0] mem);
        lsau_pkg::t_ls_in it;
        it.operation = op;
        it.base_value = base;
        it.offset = offs;
        it.rt_value = rt;
        it.memory_word = mem;
        pending_ops.push_back(it);
    endfunction

    // Mostly legal ops, some unknown codes, with extreme operands now and then
    function automatic lsau_pkg::t_ls_in random_op();
        lsau_pkg::t_ls_in it;
        if ($urandom_range(0, 19) == 0)
            it.operation = 5'($urandom_range(17, 31));
        else
            it.operation = 5'($urandom_range(0, 16));
        case ($urandom_range(0, 7))
            0: it.base_value = 32'hFFFF_FFFF;
            1: it.base_value = 32'h0000_0000;
            default: it.base_value = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0: it.offset = 16'h8000;
            1: it.offset = 16'h7FFF;
            default: it.offset = 16'($urandom);
        endcase
        it.rt_value = $urandom;
        it.memory_word = $urandom;
        return it;
    endfunction

    function automatic void check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Input driver: one transfer per accepting edge, random gaps between items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                expected_results.push_back(align_predict(i_in_data));
                ops_sent++;
            end
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_ops.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: random stall, compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        lsau_pkg::t_ls_out exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_out_data);
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("bus_address", exp_r.bus_address, o_out_data.bus_address);
                    check_field("write_enable", 32'(exp_r.write_enable),
                                32'(o_out_data.write_enable));
                    check_field("write_size", 32'(exp_r.write_size), 32'(o_out_data.write_size));
                    check_field("write_data", exp_r.write_data, o_out_data.write_data);
                    check_field("reg_write", 32'(exp_r.reg_write), 32'(o_out_data.reg_write));
                    check_field("reg_value", exp_r.reg_value, o_out_data.reg_value);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("mips_load_store_align_unit_tb: errors");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || i_in_valid || expected_results.size() != 0);
    endtask

    // Only called with the block idle
    task automatic write_isolation(logic value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        isolate_copy = value;
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_isolation(1'b0);

        // Directed: every operation, sign edges, address wrap, partial-word lanes
        push_op(lsau_pkg::OP_LUI, 32'h1234_5678, 16'h8000, 32'h0, 32'h0);
        push_op(lsau_pkg::OP_MTHI, 32'hFFFF_FFFF, 16'h0000, 32'h0, 32'h0);
        push_op(lsau_pkg::OP_MTLO, 32'h8000_0001, 16'h0000, 32'h0, 32'h0);
        push_op(lsau_pkg::OP_MFHI, 32'h0, 16'h0, 32'h0, 32'h0);
        push_op(lsau_pkg::OP_MFLO, 32'h0, 16'h0, 32'h0, 32'h0);
        push_op(lsau_pkg::OP_LB, 32'hFFFF_FFFF, 16'h0002, 32'h0, 32'h80FF_7F01);
        push_op(lsau_pkg::OP_LBU, 32'h0000_0000, 16'hFFFF, 32'h0, 32'h80FF_7F01);
        push_op(lsau_pkg::OP_LH, 32'h0000_1000, 16'h0003, 32'h0, 32'h8001_7FFE);
        push_op(lsau_pkg::OP_LHU, 32'h0000_1000, 16'h0001, 32'h0, 32'h8001_FFFE);
        push_op(lsau_pkg::OP_LW, 32'h0000_1000, 16'h7FFF, 32'h0, 32'hDEAD_BEEF);
        push_op(lsau_pkg::OP_SB, 32'hFFFF_FFFF, 16'h0001, 32'hFFFF_FFA5, 32'h0);
        push_op(lsau_pkg::OP_SH, 32'h0000_0004, 16'h8000, 32'h1234_8765, 32'h0);
        push_op(lsau_pkg::OP_SW, 32'h8000_0000, 16'hFFFE, 32'hFFFF_FFFF, 32'h0);
        push_op(5'd31, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < 4; k++) begin
            push_op((k % 2) ? lsau_pkg::OP_LWR : lsau_pkg::OP_LWL, 32'h0000_2000, 16'(k),
                    32'hA1B2_C3D4, 32'h1122_3344);
            push_op((k % 2) ? lsau_pkg::OP_LWL : lsau_pkg::OP_LWR, 32'h0000_2000, 16'(3 - k),
                    32'hA1B2_C3D4, 32'h1122_3344);
            push_op((k % 2) ? lsau_pkg::OP_SWR : lsau_pkg::OP_SWL, 32'h0000_3000, 16'(k),
                    32'hA1B2_C3D4, 32'h1122_3344);
        end
        wait_drained();

        // Directed with isolation: memory ops suppressed, hi/lo and lui unaffected
        write_isolation(1'b1);
        push_op(lsau_pkg::OP_LW, 32'h0000_1003, 16'h0000, 32'h0, 32'hCAFE_F00D);
        push_op(lsau_pkg::OP_SWL, 32'h0000_1001, 16'h0000, 32'h5555_AAAA, 32'hCAFE_F00D);
        push_op(lsau_pkg::OP_MTHI, 32'h0BAD_CAFE, 16'h0000, 32'h0, 32'h0);
        push_op(lsau_pkg::OP_MFHI, 32'h0, 16'h0, 32'h0, 32'h0);
        push_op(lsau_pkg::OP_LUI, 32'h0, 16'h7FFF, 32'h0, 32'h0);
        wait_drained();

        // Random phases across idling modes and both isolation settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_isolation((p == 3 || p == 6) ? 1'b1 : 1'b0);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_ops.push_back(random_op());
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d operations sent, %0d results checked, %0d isolation writes",
                 ops_sent, results_seen, cfg_writes);
        $display("covered all opcodes and unknown codes, every lane, four idle/stall mixes");
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("mips_load_store_align_unit_tb: clean");
        end else begin
            if (expected_results.size() != 0)
                $display("%0d results never arrived", expected_results.size());
            $display("mips_load_store_align_unit_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
